/* hdl/ber_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ber_pkg - shared definitions for the 3x3 binary erosion block
// Sizes, register map, command codes and the configuration bundle that the
// register file hands to the datapath.
// ============================================================================
package ber_pkg;

   // Storage limits
   localparam int MAX_ROW_BYTES = 512;
   localparam int MAX_ROWS      = 4096;

   // Derived widths
   localparam int COL_W   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int RB_W    = $clog2(MAX_ROW_BYTES + 1);
   localparam int RC_W    = $clog2(MAX_ROWS + 1);
   localparam int CNT_W   = $clog2(MAX_ROW_BYTES * MAX_ROWS + 1);
   localparam int DIV_CNT_W = $clog2(CNT_W + 1);

   // Register field widths
   localparam int ROW_BYTES_W = 10;
   localparam int ROW_COUNT_W = 13;
   localparam int MASK_W      = 9;

   // Register reset values
   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 10'd64;
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 13'd480;
   localparam logic [MASK_W-1:0]      MASK_RST      = 9'h1FF;

   // APB port widths
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register map (index = paddr[3:2])
   typedef enum logic [1:0] {
      REG_ROW_BYTES,
      REG_ROW_COUNT,
      REG_ELEMENT_MASK
   } reg_index_type;

   // Input command codes (carried on tuser)
   typedef enum logic {
      CMD_PIXEL,
      CMD_FLUSH
   } command_type;

   // Configuration and write events from the register file
   typedef struct packed {
      logic [ROW_BYTES_W-1:0] row_bytes;
      logic [ROW_COUNT_W-1:0] row_count;
      logic [MASK_W-1:0]      element_mask;
      logic                   rb_write;   // row_bytes written at this edge
      logic                   wr_access;  // write access phase in progress
   } cfg_type;

endpackage
`default_nettype wire

/* hdl/ber_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ber_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered; a read of the
// address being written returns the old contents.
// ============================================================================
module ber_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/ber_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ber_csr - APB register file for the 3x3 binary erosion block
// Holds row_bytes, row_count and element_mask; flags row_bytes writes so the
// datapath can rebuild its row/column counters.
// ============================================================================
module ber_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ber_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [ber_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [ber_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready,
   output ber_pkg::cfg_type                         cfg
);

   logic [ber_pkg::ROW_BYTES_W-1:0] row_bytes_ff;
   logic [ber_pkg::ROW_COUNT_W-1:0] row_count_ff;
   logic [ber_pkg::MASK_W-1:0]      mask_ff;
   logic                            wr_access;
   ber_pkg::reg_index_type          index;

   assign index      = ber_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_access  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ber_pkg::ROW_BYTES_RST;
         row_count_ff <= ber_pkg::ROW_COUNT_RST;
         mask_ff      <= ber_pkg::MASK_RST;
      end else if (wr_access) begin
         unique case (index)
            ber_pkg::REG_ROW_BYTES: begin
               row_bytes_ff <= csr_pwdata[ber_pkg::ROW_BYTES_W-1:0];
            end
            ber_pkg::REG_ROW_COUNT: begin
               row_count_ff <= csr_pwdata[ber_pkg::ROW_COUNT_W-1:0];
            end
            ber_pkg::REG_ELEMENT_MASK: begin
               mask_ff <= csr_pwdata[ber_pkg::MASK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         ber_pkg::REG_ROW_BYTES:    csr_prdata = ber_pkg::CSR_DATA_W'(row_bytes_ff);
         ber_pkg::REG_ROW_COUNT:    csr_prdata = ber_pkg::CSR_DATA_W'(row_count_ff);
         ber_pkg::REG_ELEMENT_MASK: csr_prdata = ber_pkg::CSR_DATA_W'(mask_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Bundle for the datapath
   always_comb begin
      cfg.row_bytes    = row_bytes_ff;
      cfg.row_count    = row_count_ff;
      cfg.element_mask = mask_ff;
      cfg.rb_write     = wr_access & (index == ber_pkg::REG_ROW_BYTES);
      cfg.wr_access    = wr_access;
   end

endmodule
`default_nettype wire

/* hdl/binary_erosion_3x3_masked.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// binary_erosion_3x3_masked - streaming 3x3 binary erosion, packed pixels
// Eight pixels per byte, raster order; a 9-bit mask picks the neighbours that
// are ANDed. Two row buffers in RAM, a 3x3 byte window, row/column counters.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  req     | in  | req_tvalid/tready  | tdata: pixel_byte; tuser: command
//  rsp     | out | rsp_tvalid/tready  | tdata: eroded_byte; tuser: row_end;
//          |     |                    | tlast: frame_end
//  csr     | in  | APB, pready tied 1 | row_bytes @0, row_count @4, mask @8
//
//  One item per cycle while req_tready is high; a taken item goes through the
//  line buffer read, then the window and AND into the output register.
//  Any register write holds req_tready low in its access cycle; a row_bytes
//  write then keeps it low while a radix-2 divider rebuilds the row/column
//  counters from the byte counts.
//  Reset clears counters, window and registers; line buffers are not cleared.
//  A stalled rsp holds the window stage, which holds the input.
//
module binary_erosion_3x3_masked (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] pixel_byte
   input  wire logic                           req_tuser,   // [0] command
   // result stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [7:0]                     rsp_tdata,   // [7:0] eroded_byte
   output logic                                rsp_tuser,   // [0] row_end
   output logic                                rsp_tlast,
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ber_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ber_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ber_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int COL_W  = ber_pkg::COL_W;
   localparam int RB_W   = ber_pkg::RB_W;
   localparam int RC_W   = ber_pkg::RC_W;
   localparam int CNT_W  = ber_pkg::CNT_W;
   localparam int DCNT_W = ber_pkg::DIV_CNT_W;

   typedef struct packed {
      logic [7:0]       bottom;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             pass;
      logic             left_ok;
      logic             right_ok;
      logic             row_end;
      logic             frame_end;
      logic             byp;
      logic [7:0]       byp_mid;
      logic [7:0]       byp_top;
   } stage_type;

   // AND of the selected neighbours of the center byte
   function automatic logic [7:0] erode(input logic [2:0][2:0][7:0] w,
                                        input logic [ber_pkg::MASK_W-1:0] mask,
                                        input logic left_ok,
                                        input logic right_ok);
      logic [7:0] res;
      logic [7:0] v;
      res = 8'hFF;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            v = 8'hFF;
            if (mask[r*3+c]) begin
               if (c == 0) begin
                  v = {w[r][1][6:0], right_ok & w[r][2][7]};
               end else if (c == 1) begin
                  v = w[r][1];
               end else begin
                  v = {left_ok & w[r][0][0], w[r][1][7:1]};
               end
            end
            res = res & v;
         end
      end
      return res;
   endfunction

   ber_pkg::cfg_type cfg;

   // usable sizes
   logic [RB_W-1:0]  rb_u;
   logic [RC_W-1:0]  rc_u;
   logic [CNT_W-1:0] rc_ext;
   logic [COL_W-1:0] rb_last;

   // counters
   logic [CNT_W-1:0] acc_ff, acc_row_ff, em_ff, em_row_ff;
   logic [COL_W-1:0] acc_col_ff, em_col_ff;

   // divider
   logic              div_busy_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic [CNT_W-1:0]  div_acc_ff, div_em_ff;
   logic [COL_W-1:0]  div_acc_rem_ff, div_em_rem_ff;
   logic [COL_W:0]    rb_x, acc_trial, em_trial;
   logic              acc_q, em_q;
   logic [COL_W-1:0]  acc_rem_in, em_rem_in;

   // front end
   logic             accept, drain, adv, acc_emit, emit;
   logic             acc_col_last, em_col_last;
   logic [COL_W-1:0] acc_col_inc, em_col_inc, rd_col;
   logic [CNT_W-1:0] k_row;
   logic [COL_W-1:0] k_col;
   logic             k_pass, k_row_end, k_frame_end;

   // window stage
   logic                   s1_valid_ff, s1_go;
   stage_type              s1_ff, s1_in;
   logic [7:0]             ram_mid_q, ram_top_q, mid_eff, top_eff;
   logic [2:0][2:0][7:0]   win_ff, win_in;
   logic [7:0]             res_byte;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_row_end_ff, rsp_frame_end_ff;

   ber_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Clamp registers to usable ranges
   always_comb begin
      if (cfg.row_bytes == '0) begin
         rb_u = RB_W'(1);
      end else if (32'(cfg.row_bytes) > 32'(ber_pkg::MAX_ROW_BYTES)) begin
         rb_u = RB_W'(ber_pkg::MAX_ROW_BYTES);
      end else begin
         rb_u = RB_W'(cfg.row_bytes);
      end
      if (32'(cfg.row_count) < 32'd3) begin
         rc_u = RC_W'(3);
      end else if (32'(cfg.row_count) > 32'(ber_pkg::MAX_ROWS)) begin
         rc_u = RC_W'(ber_pkg::MAX_ROWS);
      end else begin
         rc_u = RC_W'(cfg.row_count);
      end
      rc_ext  = CNT_W'(rc_u);
      rb_last = COL_W'(rb_u - RB_W'(1));
      rb_x    = (COL_W+1)'(rb_u);
   end

   // Divider step: count / row_bytes, one quotient bit per cycle
   always_comb begin
      acc_trial  = {div_acc_rem_ff, div_acc_ff[CNT_W-1]};
      acc_q      = (acc_trial >= rb_x);
      acc_rem_in = acc_q ? COL_W'(acc_trial - rb_x) : COL_W'(acc_trial);
      em_trial   = {div_em_rem_ff, div_em_ff[CNT_W-1]};
      em_q       = (em_trial >= rb_x);
      em_rem_in  = em_q ? COL_W'(em_trial - rb_x) : COL_W'(em_trial);
   end

   // Window stage handshake and input ready
   assign s1_go      = s1_valid_ff & (~s1_ff.emit | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~div_busy_ff & ~cfg.wr_access & (~s1_valid_ff | s1_go);
   assign accept     = req_tvalid & req_tready;

   // Front end: position of the item and of the byte it releases
   always_comb begin
      drain        = (acc_row_ff >= rc_ext);
      adv          = accept & (drain | (req_tuser == ber_pkg::CMD_PIXEL));
      acc_col_last = ((RB_W'(acc_col_ff) + RB_W'(1)) == rb_u);
      em_col_last  = ((RB_W'(em_col_ff) + RB_W'(1)) == rb_u);
      acc_col_inc  = acc_col_last ? '0 : COL_W'(acc_col_ff + COL_W'(1));
      em_col_inc   = em_col_last ? '0 : COL_W'(em_col_ff + COL_W'(1));
      acc_emit     = (acc_row_ff >= CNT_W'(2)) |
                     ((acc_row_ff == CNT_W'(1)) & (acc_col_ff != '0));
      emit         = drain | acc_emit;

      if (drain) begin
         k_row = em_row_ff;
         k_col = em_col_ff;
      end else if (acc_col_ff != '0) begin
         k_row = CNT_W'(acc_row_ff - CNT_W'(1));
         k_col = COL_W'(acc_col_ff - COL_W'(1));
      end else begin
         k_row = CNT_W'(acc_row_ff - CNT_W'(2));
         k_col = rb_last;
      end
      k_pass      = (k_row == '0) | (CNT_W'(k_row + CNT_W'(1)) >= rc_ext);
      k_row_end   = (k_col == rb_last);
      k_frame_end = (k_row >= rc_ext) |
                    ((k_row == CNT_W'(rc_ext - CNT_W'(1))) & k_row_end);
      rd_col      = drain ? em_col_inc : acc_col_ff;

      s1_in.bottom    = drain ? 8'h00 : req_tdata;
      s1_in.col       = rd_col;
      s1_in.emit      = emit;
      s1_in.pass      = k_pass;
      s1_in.left_ok   = (k_col != '0);
      s1_in.right_ok  = ~k_row_end;
      s1_in.row_end   = k_row_end;
      s1_in.frame_end = k_frame_end;
      // previous item writes the same column at this edge
      s1_in.byp       = s1_valid_ff & (s1_ff.col == rd_col);
      s1_in.byp_mid   = s1_ff.bottom;
      s1_in.byp_top   = mid_eff;
   end

   // Counters and the rebuild divider
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         acc_row_ff   <= '0;
         acc_col_ff   <= '0;
         em_ff        <= '0;
         em_row_ff    <= '0;
         em_col_ff    <= '0;
         div_busy_ff  <= 1'b0;
         div_cnt_ff   <= '0;
      end else if (cfg.rb_write) begin
         div_busy_ff    <= 1'b1;
         div_cnt_ff     <= DCNT_W'(CNT_W);
         div_acc_ff     <= acc_ff;
         div_em_ff      <= em_ff;
         div_acc_rem_ff <= '0;
         div_em_rem_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff     <= DCNT_W'(div_cnt_ff - DCNT_W'(1));
         div_acc_ff     <= {div_acc_ff[CNT_W-2:0], acc_q};
         div_em_ff      <= {div_em_ff[CNT_W-2:0], em_q};
         div_acc_rem_ff <= acc_rem_in;
         div_em_rem_ff  <= em_rem_in;
         if (div_cnt_ff == DCNT_W'(1)) begin
            div_busy_ff <= 1'b0;
            acc_row_ff  <= {div_acc_ff[CNT_W-2:0], acc_q};
            acc_col_ff  <= acc_rem_in;
            em_row_ff   <= {div_em_ff[CNT_W-2:0], em_q};
            em_col_ff   <= em_rem_in;
         end
      end else if (adv) begin
         if (emit & k_frame_end) begin
            acc_ff     <= '0;
            acc_row_ff <= '0;
            acc_col_ff <= '0;
            em_ff      <= '0;
            em_row_ff  <= '0;
            em_col_ff  <= '0;
         end else if (drain) begin
            em_ff     <= CNT_W'(em_ff + CNT_W'(1));
            em_col_ff <= em_col_inc;
            if (em_col_last) begin
               em_row_ff <= CNT_W'(em_row_ff + CNT_W'(1));
            end
         end else begin
            acc_ff     <= CNT_W'(acc_ff + CNT_W'(1));
            acc_col_ff <= acc_col_inc;
            if (acc_col_last) begin
               acc_row_ff <= CNT_W'(acc_row_ff + CNT_W'(1));
            end
            if (acc_emit) begin
               em_ff     <= CNT_W'(acc_ff - CNT_W'(rb_u));
               em_row_ff <= CNT_W'(acc_row_ff - CNT_W'(1));
               em_col_ff <= acc_col_ff;
            end
         end
      end
   end

   // Line buffers: middle row (newest) and top row
   ber_ram #(
      .WIDTH (8),
      .DEPTH (ber_pkg::MAX_ROW_BYTES)
   ) u_ram_mid (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.bottom),
      .rd_en   (adv),
      .rd_addr (rd_col),
      .rd_data (ram_mid_q)
   );

   ber_ram #(
      .WIDTH (8),
      .DEPTH (ber_pkg::MAX_ROW_BYTES)
   ) u_ram_top (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (mid_eff),
      .rd_en   (adv),
      .rd_addr (rd_col),
      .rd_data (ram_top_q)
   );

   // Window shift and erosion
   always_comb begin
      mid_eff = s1_ff.byp ? s1_ff.byp_mid : ram_mid_q;
      top_eff = s1_ff.byp ? s1_ff.byp_top : ram_top_q;
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = top_eff;
      win_in[1][2] = mid_eff;
      win_in[2][2] = s1_ff.bottom;
      res_byte = s1_ff.pass ? win_in[1][1] :
                 erode(win_in, cfg.element_mask, s1_ff.left_ok, s1_ff.right_ok);
   end

   // Window stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         if (adv) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            win_ff <= (s1_ff.emit & s1_ff.frame_end) ? '0 : win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go & s1_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go & s1_ff.emit) begin
         rsp_data_ff      <= res_byte;
         rsp_row_end_ff   <= s1_ff.row_end;
         rsp_frame_end_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_row_end_ff;
   assign rsp_tlast  = rsp_frame_end_ff;

endmodule
`default_nettype wire

/* bench/erosion_check.sv */
`timescale 1ns / 1ps
// ============================================================================
// erosion_check - result predictor and comparator for the 3x3 erosion block
// Watches the register port and both streams, keeps its own copy of the row
// buffers, the byte window and the frame counters, and compares every result
// transaction field by field with the oldest predicted byte.
// ============================================================================
module erosion_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] pixel_byte
   input  logic                           req_tuser,   // [0] command
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [7:0]                     rsp_tdata,   // [7:0] eroded_byte
   input  logic                           rsp_tuser,   // [0] row_end
   input  logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ber_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ber_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             pending,
   output int                             checked,
   output int                             fail_count
);

   typedef struct packed {
      logic [7:0] eroded;
      logic       row_end;
      logic       frame_end;
   } erosion_result_type;

   // register copies
   logic [ber_pkg::ROW_BYTES_W-1:0] width_reg;
   logic [ber_pkg::ROW_COUNT_W-1:0] height_reg;
   logic [ber_pkg::MASK_W-1:0]      mask_reg;

   // two row delay lines (mid row low half, top row high half) and the window
   logic [7:0]  line_mem [2*ber_pkg::MAX_ROW_BYTES];
   logic [7:0]  win [3][3];
   int unsigned bytes_in;
   int unsigned bytes_out;

   erosion_result_type eroded_q [$];
   int results_seen;
   int errors;

   assign checked    = results_seen;
   assign fail_count = errors;

   function automatic int unsigned used_width();
      if (width_reg == 0) return 1;
      if (width_reg > ber_pkg::MAX_ROW_BYTES) return ber_pkg::MAX_ROW_BYTES;
      return width_reg;
   endfunction

   function automatic int unsigned used_height();
      if (height_reg < 3) return 3;
      if (height_reg > ber_pkg::MAX_ROWS) return ber_pkg::MAX_ROWS;
      return height_reg;
   endfunction

   // shift the window one byte right; pos is the stream index of the new bottom byte
   function automatic void slide_window(int unsigned pos, int unsigned rb,
                                        logic [7:0] bottom);
      int unsigned col;
      logic [7:0]  mid;
      logic [7:0]  top;
      col = pos % rb;
      mid = line_mem[col];
      top = line_mem[ber_pkg::MAX_ROW_BYTES + col];
      line_mem[ber_pkg::MAX_ROW_BYTES + col] = mid;
      line_mem[col] = bottom;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bottom;
   endfunction

   // erode the byte at frame index k from the current window
   function automatic void predict_byte(int unsigned k, int unsigned rb);
      int unsigned        rows;
      int unsigned        y;
      int unsigned        b;
      logic [7:0]         acc;
      logic [7:0]         cen;
      logic [7:0]         term;
      erosion_result_type res;
      rows = used_height();
      y    = k / rb;
      b    = k % rb;
      if (y == 0 || y + 1 >= rows) begin
         // first and last rows pass through
         acc = win[1][1];
      end else begin
         acc = 8'hFF;
         for (int r = 0; r < 3; r++) begin
            cen = win[r][1];
            for (int c = 0; c < 3; c++) begin
               if (mask_reg[r*3 + c]) begin
                  case (c)
                     0: begin
                        // right neighbor; zero past the row end
                        term = cen << 1;
                        if (b + 1 < rb) term[0] = win[r][2][7];
                     end
                     1: term = cen;
                     default: begin
                        // left neighbor; zero before the row start
                        term = cen >> 1;
                        if (b > 0) term[7] = win[r][0][0];
                     end
                  endcase
                  acc &= term;
               end
            end
         end
      end
      res.eroded    = acc;
      res.row_end   = (b + 1 == rb);
      res.frame_end = 1'b0;
      bytes_out     = k + 1;
      if (k + 1 >= rb * rows) begin
         res.frame_end = 1'b1;
         bytes_in  = 0;
         bytes_out = 0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               win[r][c] = 8'h00;
      end
      eroded_q.push_back(res);
   endfunction

   // one accepted input transaction
   function automatic void take_item(ber_pkg::command_type cmd, logic [7:0] px);
      int unsigned rb;
      int unsigned n;
      rb = used_width();
      if (bytes_in >= rb * used_height()) begin
         // frame fully taken: any item drains one byte
         n = bytes_out;
         slide_window(n + rb + 1, rb, 8'h00);
         predict_byte(n, rb);
      end else if (cmd == ber_pkg::CMD_PIXEL) begin
         n = bytes_in;
         slide_window(n, rb, px);
         bytes_in = n + 1;
         if (n >= rb + 1) predict_byte(n - rb - 1, rb);
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] ERROR result %0d: %s", $time, results_seen, what);
      errors++;
   endtask

   always @(posedge clock) begin
      erosion_result_type want;
      if (reset) begin
         width_reg  = ber_pkg::ROW_BYTES_RST;
         height_reg = ber_pkg::ROW_COUNT_RST;
         mask_reg   = ber_pkg::MASK_RST;
         for (int i = 0; i < 2*ber_pkg::MAX_ROW_BYTES; i++) line_mem[i] = 8'h00;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               win[r][c] = 8'h00;
         bytes_in  = 0;
         bytes_out = 0;
         eroded_q.delete();
         pending <= 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (ber_pkg::reg_index_type'(csr_paddr[3:2]))
               ber_pkg::REG_ROW_BYTES:
                  width_reg  = csr_pwdata[ber_pkg::ROW_BYTES_W-1:0];
               ber_pkg::REG_ROW_COUNT:
                  height_reg = csr_pwdata[ber_pkg::ROW_COUNT_W-1:0];
               ber_pkg::REG_ELEMENT_MASK:
                  mask_reg   = csr_pwdata[ber_pkg::MASK_W-1:0];
               default: ;
            endcase
         end
         // result transactions, checked before new predictions are queued
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (eroded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, eroded_byte %02h", rsp_tdata));
            end else begin
               want = eroded_q.pop_front();
               if (rsp_tdata !== want.eroded)
                  report_mismatch($sformatf("eroded_byte %02h, predicted %02h",
                                            rsp_tdata, want.eroded));
               if (rsp_tuser !== want.row_end)
                  report_mismatch($sformatf("row_end %b, predicted %b",
                                            rsp_tuser, want.row_end));
               if (rsp_tlast !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, predicted %b",
                                            rsp_tlast, want.frame_end));
            end
         end
         // input transactions
         if (req_tvalid && req_tready)
            take_item(ber_pkg::command_type'(req_tuser), req_tdata);
         pending <= eroded_q.size();
      end
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top - stimulus and verdict for binary_erosion_3x3_masked
// Programs frame geometry and structuring element between frames, streams
// whole frames with flush noise and drain items, stalls both streams at
// random, and reports the outcome of the attached erosion_check.
// ============================================================================
module tb_top;

   localparam int RAND_ITEMS  = 1150;
   localparam int STALL_LIMIT = 2000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = 8'h00;   // [7:0] pixel_byte
   logic                           req_tuser = 1'b0;    // [0] command
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;           // [7:0] eroded_byte
   logic                           rsp_tuser;           // [0] row_end
   logic                           rsp_tlast;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [ber_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ber_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ber_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   int pending;
   int checked;
   int fail_count;

   int          src_idle_pct = 38;
   int          dst_idle_pct = 73;
   int unsigned cur_width;
   int unsigned cur_height;
   int          stream_items = 0;
   int          frames = 0;
   int          settings = 0;
   int          stall_cycles = 0;

   binary_erosion_3x3_masked DUT (.*);

   erosion_check u_erosion_check (.*);

   always #10 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= dst_idle_pct);

   // watchdog: no transaction of any kind for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("binary_erosion_3x3_masked: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input ber_pkg::command_type cmd, input logic [7:0] px);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      stream_items++;
   endtask

   // APB write; unused upper data bits carry noise
   task automatic csr_write(input ber_pkg::reg_index_type idx, input int unsigned value,
                            input int width);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ber_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= (($urandom >> width) << width) | value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // all predicted results out, then a wait for items still in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_frame(input logic [ber_pkg::ROW_BYTES_W-1:0] rb,
                            input logic [ber_pkg::ROW_COUNT_W-1:0] rc,
                            input logic [ber_pkg::MASK_W-1:0] mask);
      wait_idle();
      csr_write(ber_pkg::REG_ROW_BYTES, rb, ber_pkg::ROW_BYTES_W);
      csr_write(ber_pkg::REG_ROW_COUNT, rc, ber_pkg::ROW_COUNT_W);
      csr_write(ber_pkg::REG_ELEMENT_MASK, mask, ber_pkg::MASK_W);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      cur_width  = (rb == 0) ? 1 :
                   ((rb > ber_pkg::MAX_ROW_BYTES) ? ber_pkg::MAX_ROW_BYTES : rb);
      cur_height = (rc < 3) ? 3 : ((rc > ber_pkg::MAX_ROWS) ? ber_pkg::MAX_ROWS : rc);
      settings++;
   endtask

   // one full frame: pixels with stray flushes, then the drain items
   task automatic run_frame();
      int unsigned total;
      logic [7:0]  px;
      total = cur_width * cur_height;
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(99) < 8) send_item(ber_pkg::CMD_FLUSH, 8'($urandom));
         case ($urandom_range(3))
            0, 1:    px = 8'hFF;
            2:       px = ~(8'h01 << $urandom_range(7));
            default: px = 8'($urandom);
         endcase
         send_item(ber_pkg::CMD_PIXEL, px);
      end
      for (int unsigned i = 0; i <= cur_width; i++)
         send_item($urandom_range(1) ? ber_pkg::CMD_FLUSH : ber_pkg::CMD_PIXEL,
                   8'($urandom));
      // a flush at the start of the next frame is ignored
      if ($urandom_range(3) == 0) send_item(ber_pkg::CMD_FLUSH, 8'($urandom));
      frames++;
   endtask

   initial begin
      logic [ber_pkg::ROW_BYTES_W-1:0] rb;
      logic [ber_pkg::ROW_COUNT_W-1:0] rc;
      logic [ber_pkg::MASK_W-1:0]      mask;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clamped geometry and empty element, early flushes,
      // a pixel byte acting as a drain tick, a flush after the frame end
      set_frame(10'd0, 13'd1, 9'h000);
      send_item(ber_pkg::CMD_FLUSH, 8'hFF);
      send_item(ber_pkg::CMD_PIXEL, 8'hFF);
      send_item(ber_pkg::CMD_PIXEL, 8'h00);
      send_item(ber_pkg::CMD_FLUSH, 8'h00);
      send_item(ber_pkg::CMD_PIXEL, 8'h81);
      send_item(ber_pkg::CMD_PIXEL, 8'hAA);
      send_item(ber_pkg::CMD_FLUSH, 8'h55);
      send_item(ber_pkg::CMD_FLUSH, 8'h00);
      frames++;

      // directed: full element, row edges zero-filled
      set_frame(10'd2, 13'd3, 9'h1FF);
      send_item(ber_pkg::CMD_PIXEL, 8'hFF);
      send_item(ber_pkg::CMD_PIXEL, 8'hFF);
      send_item(ber_pkg::CMD_PIXEL, 8'hFF);
      send_item(ber_pkg::CMD_PIXEL, 8'hFF);
      send_item(ber_pkg::CMD_PIXEL, 8'h80);
      send_item(ber_pkg::CMD_PIXEL, 8'h01);
      send_item(ber_pkg::CMD_PIXEL, 8'h7E);
      send_item(ber_pkg::CMD_FLUSH, 8'h00);
      send_item(ber_pkg::CMD_FLUSH, 8'h00);
      frames++;

      // random frames of small geometry, three idle profiles
      while (stream_items < RAND_ITEMS) begin
         if (stream_items < RAND_ITEMS / 3) begin
            src_idle_pct = 38;
            dst_idle_pct = 73;
         end else if (stream_items < 2 * RAND_ITEMS / 3) begin
            src_idle_pct = 73;
            dst_idle_pct = 38;
         end else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
         end
         case ($urandom_range(9))
            0:       rb = 10'd0;
            1:       rb = 10'($urandom_range(7, 40));
            default: rb = 10'($urandom_range(1, 6));
         endcase
         if (rb > 6) rc = 13'd3;
         else if ($urandom_range(9) == 0) rc = 13'($urandom_range(2));
         else rc = 13'($urandom_range(3, 6));
         case ($urandom_range(5))
            0:       mask = 9'h000;
            1:       mask = 9'h1FF;
            2:       mask = 9'h001 << $urandom_range(8);
            default: mask = 9'($urandom);
         endcase
         set_frame(rb, rc, mask);
         run_frame();
      end

      wait_idle();
      $display("covered %0d frames over %0d register settings, %0d items, %0d results checked",
               frames, settings, stream_items, checked);
      $display("rows of 1 to 40 bytes, 3 to 6 rows, clamped sizes, empty/full/random elements");
      if (fail_count == 0 && pending == 0)
         $display("binary_erosion_3x3_masked: match");
      else
         $display("binary_erosion_3x3_masked: mismatch");
      $finish;
   end

endmodule

/* sim.f */
hdl/ber_pkg.sv
hdl/ber_ram.sv
hdl/ber_csr.sv
hdl/binary_erosion_3x3_masked.sv
bench/erosion_check.sv
bench/tb_top.sv
